@@ hdl/ssrt_pkg.sv @@
// shared types and constants for the sorted segment region table
`default_nettype none
package ssrt_pkg;

  localparam int unsigned NumRegions = 3;

  // item kinds
  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  // result status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusZero     = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;
  localparam logic [1:0] StatusNotFound = 2'd3;

  // region codes
  localparam logic [1:0] RegionStack  = 2'd0;
  localparam logic [1:0] RegionHeap   = 2'd1;
  localparam logic [1:0] RegionStatic = 2'd2;
  localparam logic [1:0] RegionNone   = 2'd3;

  // input word
  typedef struct packed {
    logic        kind;
    logic [1:0]  region;
    logic [31:0] start_addr;
    logic [31:0] end_addr;
    logic [31:0] overflow_end;
    logic [15:0] elem_size;
  } req_t;

  // result word
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  region_hit;
    logic [31:0] extent_start;
    logic [31:0] extent_end;
    logic [4:0]  entry_count;
  } rsp_t;

endpackage
`default_nettype wire

@@ hdl/ssrt_req_if.sv @@
// valid/ready channel that carries request words
`default_nettype none
interface ssrt_req_if;
  logic              valid;
  logic              ready;
  ssrt_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/ssrt_rsp_if.sv @@
// valid/ready channel that carries result words
`default_nettype none
interface ssrt_rsp_if;
  logic              valid;
  logic              ready;
  ssrt_pkg::rsp_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/sorted_segment_region_table_core.sv @@
// top level: segment tables per region in one memory, sequenced insert and remove
// allocate: extent update, then a read and compare per entry walked (moving greater ones up), then the put;
//   a rejected allocate goes straight to the result; free searches, shifts later entries down, then updates
// throughput: one word at a time, set by the single-port segment memory (one access a cycle)
// reset clears the region extents and counts; the segment memory is left as is
// results wait in an output register, the next word is taken while one waits
`default_nettype none
module sorted_segment_region_table_core #(
  parameter int unsigned SEG_DEPTH = 16,
  parameter int unsigned ADDR_BITS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ssrt_req_if.sink   req_i,
  ssrt_rsp_if.source rsp_o
);

  localparam int unsigned MemDepth = ssrt_pkg::NumRegions * SEG_DEPTH;
  localparam int unsigned MemAw    = $clog2(MemDepth);
  localparam int unsigned IdxW     = $clog2(SEG_DEPTH + 1);

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [IdxW-1:0]      idx_t;
  typedef struct packed {
    addr_t s;
    addr_t e;
    addr_t o;
  } seg_t;

  localparam idx_t IdxOne  = idx_t'(1);
  localparam idx_t IdxFull = idx_t'(SEG_DEPTH);

  typedef enum logic [3:0] {
    StIdle, StExtLo, StExtHi, StInsRd, StInsChk, StInsPut,
    StFreeRd, StFreeChk, StShRd, StShWr, StFinRd, StFinUpd, StOut
  } state_e;

  state_e     st_q;
  addr_t      low_q  [ssrt_pkg::NumRegions];
  addr_t      high_q [ssrt_pkg::NumRegions];
  idx_t       used_q [ssrt_pkg::NumRegions];
  logic [1:0] r_q;
  idx_t       i_q, pos_q, n_q;
  addr_t      s_q, e_q, ov_q;
  logic [15:0] sz_q;
  logic       ovalid_q;
  ssrt_pkg::rsp_t odata_q;
  logic [1:0] pst_q;
  logic [1:0] phit_q;

  // segment memory
  seg_t             mem_q [MemDepth];
  seg_t             rd_q;
  logic [MemAw-1:0] ma;
  logic             mwe;
  seg_t             mwd;

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      mem_q[ma] <= mwd;
    end
    rd_q <= mem_q[ma];
  end

  function automatic logic [MemAw-1:0] addr_of(logic [1:0] r, idx_t i);
    return MemAw'(r * SEG_DEPTH + i);
  endfunction

  // memory port select
  always_comb begin
    mwe = 1'b0;
    mwd = rd_q;
    ma  = addr_of(r_q, i_q);
    case (st_q)
      StInsChk: begin
        // move a greater entry one slot up
        mwe = (rd_q.s > s_q);
        ma  = addr_of(r_q, i_q + IdxOne);
      end
      StInsPut: begin
        mwe = 1'b1;
        ma  = addr_of(r_q, pos_q);
        mwd = '{s: s_q, e: e_q, o: ov_q};
      end
      StShRd:  ma = addr_of(r_q, i_q + IdxOne);
      StShWr:  mwe = 1'b1;
      StFinRd: ma = addr_of(r_q, (pos_q == '0) ? '0 : pos_q - IdxOne);
      default: ;
    endcase
  end

  // extent arithmetic
  addr_t sum_w;
  addr_t hi_e_w;
  addr_t hi_new_w;
  assign sum_w    = s_q + addr_t'(sz_q);
  assign hi_e_w   = (high_q[r_q] < e_q) ? e_q : high_q[r_q];
  assign hi_new_w = (ov_q != '0 && hi_e_w < ov_q) ? ov_q : hi_e_w;

  logic out_load;
  assign out_load = (st_q == StOut) && (!ovalid_q || rsp_o.ready);

  assign req_i.ready = (st_q == StIdle);
  assign rsp_o.valid = ovalid_q;
  assign rsp_o.data  = odata_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      ovalid_q <= 1'b0;
      odata_q  <= '0;
      r_q      <= '0;
      i_q      <= '0;
      pos_q    <= '0;
      n_q      <= '0;
      s_q      <= '0;
      e_q      <= '0;
      ov_q     <= '0;
      sz_q     <= '0;
      pst_q    <= '0;
      phit_q   <= '0;
      for (int k = 0; k < ssrt_pkg::NumRegions; k++) begin
        low_q[k]  <= '0;
        high_q[k] <= '0;
        used_q[k] <= '0;
      end
    end else begin
      ovalid_q <= out_load || (ovalid_q && !rsp_o.ready);
      case (st_q)
        StIdle: begin
          if (req_i.valid && req_i.ready) begin
            s_q  <= addr_t'(req_i.data.start_addr);
            e_q  <= addr_t'(req_i.data.end_addr);
            ov_q <= addr_t'(req_i.data.overflow_end);
            sz_q <= req_i.data.elem_size;
            i_q  <= '0;
            if (req_i.data.kind == ssrt_pkg::KindFree) begin
              r_q  <= ssrt_pkg::RegionStack;
              st_q <= StFreeRd;
            end else if (req_i.data.region == ssrt_pkg::RegionNone) begin
              pst_q <= ssrt_pkg::StatusNotFound; phit_q <= ssrt_pkg::RegionNone;
              st_q <= StOut;
            end else begin
              r_q <= req_i.data.region;
              phit_q <= req_i.data.region;
              if (addr_t'(req_i.data.start_addr) == '0) begin
                pst_q <= ssrt_pkg::StatusZero; st_q <= StOut;
              end else if (used_q[req_i.data.region] >= IdxFull) begin
                pst_q <= ssrt_pkg::StatusFull; st_q <= StOut;
              end else begin
                pst_q <= ssrt_pkg::StatusOk;
                n_q <= used_q[req_i.data.region];
                st_q <= StExtLo;
              end
            end
          end
        end
        // allocate: low side of the extent, or high to start plus size, and default end
        StExtLo: begin
          if (low_q[r_q] == '0 || low_q[r_q] > s_q) low_q[r_q] <= s_q;
          else if (high_q[r_q] < s_q) high_q[r_q] <= sum_w;
          if (e_q == '0) e_q <= sum_w;
          st_q <= StExtHi;
        end
        // allocate: raise the extent to end and overflow end
        StExtHi: begin
          high_q[r_q] <= hi_new_w;
          if (n_q == '0) begin
            pos_q <= '0; st_q <= StInsPut;
          end else begin
            i_q <= n_q - IdxOne; st_q <= StInsRd;
          end
        end
        StInsRd: st_q <= StInsChk;
        // walk down from the last entry, moving greater starts up
        StInsChk: begin
          if (rd_q.s > s_q) begin
            if (i_q == '0) begin
              pos_q <= '0; st_q <= StInsPut;
            end else begin
              i_q <= i_q - IdxOne; st_q <= StInsRd;
            end
          end else begin
            pos_q <= i_q + IdxOne; st_q <= StInsPut;
          end
        end
        StInsPut: begin
          used_q[r_q] <= n_q + IdxOne;
          st_q <= StOut;
        end
        // free: search regions in order
        StFreeRd: begin
          if (i_q == used_q[r_q]) begin
            if (r_q == ssrt_pkg::RegionStatic) begin
              pst_q <= ssrt_pkg::StatusNotFound; phit_q <= ssrt_pkg::RegionNone;
              st_q <= StOut;
            end else begin
              r_q <= r_q + 2'd1; i_q <= '0;
            end
          end else st_q <= StFreeChk;
        end
        StFreeChk: begin
          if (rd_q.s == s_q) begin
            pos_q <= i_q; n_q <= used_q[r_q];
            pst_q <= ssrt_pkg::StatusOk; phit_q <= r_q;
            st_q <= StShRd;
          end else begin
            i_q <= i_q + IdxOne; st_q <= StFreeRd;
          end
        end
        // close the gap one entry at a time
        StShRd: begin
          if (i_q + IdxOne == n_q) st_q <= StFinRd;
          else st_q <= StShWr;
        end
        StShWr: begin
          i_q <= i_q + IdxOne; st_q <= StShRd;
        end
        StFinRd: st_q <= StFinUpd;
        // free: extent after removal
        StFinUpd: begin
          used_q[r_q] <= n_q - IdxOne;
          if (pos_q == '0) begin
            if (n_q != IdxOne) low_q[r_q] <= rd_q.s;
            else begin
              low_q[r_q] <= '0; high_q[r_q] <= '0;
            end
          end else if (pos_q == n_q - IdxOne) high_q[r_q] <= rd_q.e;
          st_q <= StOut;
        end
        StOut: begin
          if (out_load) begin
            odata_q.status     <= pst_q;
            odata_q.region_hit <= phit_q;
            if (phit_q == ssrt_pkg::RegionNone) begin
              odata_q.extent_start <= '0;
              odata_q.extent_end   <= '0;
              odata_q.entry_count  <= '0;
            end else begin
              odata_q.extent_start <= 32'(low_q[phit_q]);
              odata_q.extent_end   <= 32'(high_q[phit_q]);
              odata_q.entry_count  <= 5'(used_q[phit_q]);
            end
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ dv/sorted_segment_region_table_core_tb.sv @@
// self-checking testbench for the sorted segment region table core
`timescale 1ns / 1ps
module sorted_segment_region_table_core_tb;

  localparam int Depth = 16;
  localparam longint MaxCycles = 2_000_000;

  logic clk_i;
  logic rst_ni;

  ssrt_req_if req_if ();
  ssrt_rsp_if rsp_if ();

  sorted_segment_region_table_core #(.SEG_DEPTH(Depth), .ADDR_BITS(32)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // shadow copy of the segment tables
  logic [31:0] shadow_start [3][Depth];
  logic [31:0] shadow_end   [3][Depth];
  logic [31:0] shadow_over  [3][Depth];
  logic [31:0] shadow_low   [3];
  logic [31:0] shadow_high  [3];
  int          shadow_used  [3];

  ssrt_pkg::req_t pending_words [$];
  ssrt_pkg::rsp_t expected_rsps [$];
  int   errors;
  int   send_idle_pct;
  int   recv_idle_pct;
  longint cycle_cnt;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic ssrt_pkg::rsp_t region_view(logic [1:0] status, logic [1:0] hit);
    ssrt_pkg::rsp_t r;
    r.status = status;
    r.region_hit = hit;
    if (hit != ssrt_pkg::RegionNone) begin
      r.extent_start = shadow_low[hit];
      r.extent_end = shadow_high[hit];
      r.entry_count = 5'(shadow_used[hit]);
    end else begin
      r.extent_start = '0;
      r.extent_end = '0;
      r.entry_count = '0;
    end
    return r;
  endfunction

  // insert a segment in start order and widen the extent
  function automatic ssrt_pkg::rsp_t apply_alloc(ssrt_pkg::req_t w);
    int g;
    int n;
    int pos;
    logic [31:0] seg_end;
    g = w.region;
    if (w.region == ssrt_pkg::RegionNone)
      return region_view(ssrt_pkg::StatusNotFound, ssrt_pkg::RegionNone);
    if (w.start_addr == 0) return region_view(ssrt_pkg::StatusZero, w.region);
    n = shadow_used[g];
    if (n >= Depth) return region_view(ssrt_pkg::StatusFull, w.region);
    if (shadow_low[g] == 0 || shadow_low[g] > w.start_addr) shadow_low[g] = w.start_addr;
    else if (shadow_high[g] < w.start_addr) shadow_high[g] = w.start_addr + w.elem_size;
    seg_end = (w.end_addr == 0) ? w.start_addr + w.elem_size : w.end_addr;
    if (shadow_high[g] < seg_end) shadow_high[g] = seg_end;
    if (w.overflow_end != 0 && shadow_high[g] < w.overflow_end) shadow_high[g] = w.overflow_end;
    pos = n;
    for (int i = 0; i < n; i++) begin
      if (shadow_start[g][i] > w.start_addr) begin
        pos = i;
        break;
      end
    end
    for (int i = n; i > pos; i--) begin
      shadow_start[g][i] = shadow_start[g][i-1];
      shadow_end[g][i] = shadow_end[g][i-1];
      shadow_over[g][i] = shadow_over[g][i-1];
    end
    shadow_start[g][pos] = w.start_addr;
    shadow_end[g][pos] = seg_end;
    shadow_over[g][pos] = w.overflow_end;
    shadow_used[g] = n + 1;
    return region_view(ssrt_pkg::StatusOk, w.region);
  endfunction

  // remove the first matching segment, stack then heap then static
  function automatic ssrt_pkg::rsp_t apply_free(logic [31:0] addr);
    int n;
    int pos;
    for (int g = 0; g < 3; g++) begin
      n = shadow_used[g];
      pos = n;
      for (int i = 0; i < n; i++) begin
        if (shadow_start[g][i] == addr) begin
          pos = i;
          break;
        end
      end
      if (pos < n) begin
        for (int i = pos; i + 1 < n; i++) begin
          shadow_start[g][i] = shadow_start[g][i+1];
          shadow_end[g][i] = shadow_end[g][i+1];
          shadow_over[g][i] = shadow_over[g][i+1];
        end
        n--;
        shadow_used[g] = n;
        if (pos == 0) begin
          if (n > 0) shadow_low[g] = shadow_start[g][0];
          else begin
            shadow_low[g] = '0;
            shadow_high[g] = '0;
          end
        end else if (pos == n) begin
          shadow_high[g] = shadow_end[g][pos-1];
        end
        return region_view(ssrt_pkg::StatusOk, 2'(g));
      end
    end
    return region_view(ssrt_pkg::StatusNotFound, ssrt_pkg::RegionNone);
  endfunction

  function automatic ssrt_pkg::req_t make_word(logic kind, logic [1:0] region,
                                               logic [31:0] s, logic [31:0] e,
                                               logic [31:0] ov, logic [15:0] sz);
    ssrt_pkg::req_t w;
    w.kind = kind;
    w.region = region;
    w.start_addr = s;
    w.end_addr = e;
    w.overflow_end = ov;
    w.elem_size = sz;
    return w;
  endfunction

  // small address pool so frees hit and starts collide
  function automatic logic [31:0] pool_addr();
    return 32'h1000 + 32'($urandom_range(1, 40)) * 32'h10;
  endfunction

  // sender: drive words from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req_if.valid <= 1'b1;
        req_if.data <= pending_words.pop_front();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // predict on every accepted word
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      if (req_if.data.kind == ssrt_pkg::KindAlloc)
        expected_rsps.push_back(apply_alloc(req_if.data));
      else expected_rsps.push_back(apply_free(req_if.data.start_addr));
    end
  end

  // receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // compare accepted results with the oldest expectation
  always @(posedge clk_i) begin
    ssrt_pkg::rsp_t exp_w;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, rsp_if.data);
        errors++;
      end else begin
        exp_w = expected_rsps.pop_front();
        if (rsp_if.data !== exp_w) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_w, rsp_if.data);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MaxCycles) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || req_if.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [1:0] rg;
    logic [31:0] s;
    errors = 0;
    cycle_cnt = 0;
    send_idle_pct = 32;
    recv_idle_pct = 85;
    for (int g = 0; g < 3; g++) begin
      shadow_low[g] = '0;
      shadow_high[g] = '0;
      shadow_used[g] = 0;
    end
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: special cases and field extremes
    pending_words.push_back(make_word(ssrt_pkg::KindFree, ssrt_pkg::RegionStack, 32'h1234,
                                      32'h0, 32'h0, 16'h0));
    pending_words.push_back(make_word(ssrt_pkg::KindAlloc, ssrt_pkg::RegionStack, 32'h0,
                                      32'h0, 32'h0, 16'hFFFF));
    pending_words.push_back(make_word(ssrt_pkg::KindAlloc, ssrt_pkg::RegionNone, 32'h100,
                                      32'h0, 32'h0, 16'h4));
    pending_words.push_back(make_word(ssrt_pkg::KindAlloc, ssrt_pkg::RegionStack, 32'hFFFF_FFFF,
                                      32'h0, 32'h0, 16'hFFFF));
    pending_words.push_back(make_word(ssrt_pkg::KindAlloc, ssrt_pkg::RegionHeap, 32'h200,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8));
    pending_words.push_back(make_word(ssrt_pkg::KindAlloc, ssrt_pkg::RegionStatic, 32'h300,
                                      32'h0, 32'h400, 16'h4));
    pending_words.push_back(make_word(ssrt_pkg::KindAlloc, ssrt_pkg::RegionStatic, 32'h300,
                                      32'h310, 32'h0, 16'h4));
    pending_words.push_back(make_word(ssrt_pkg::KindAlloc, ssrt_pkg::RegionStatic, 32'h100,
                                      32'h104, 32'h0, 16'h4));
    pending_words.push_back(make_word(ssrt_pkg::KindFree, ssrt_pkg::RegionStatic, 32'h300,
                                      32'h0, 32'h0, 16'h0));
    pending_words.push_back(make_word(ssrt_pkg::KindFree, ssrt_pkg::RegionStack, 32'h300,
                                      32'h0, 32'h0, 16'h0));
    pending_words.push_back(make_word(ssrt_pkg::KindFree, ssrt_pkg::RegionStack, 32'h100,
                                      32'h0, 32'h0, 16'h0));
    // fill the heap to the full case
    for (int i = 0; i < 17; i++)
      pending_words.push_back(make_word(ssrt_pkg::KindAlloc, ssrt_pkg::RegionHeap,
                                        32'h500 + 32'(i) * 4, 32'h0, 32'h0, 16'h4));
    pending_words.push_back(make_word(ssrt_pkg::KindAlloc, ssrt_pkg::RegionHeap, 32'h0,
                                      32'h0, 32'h0, 16'h4));
    pending_words.push_back(make_word(ssrt_pkg::KindFree, ssrt_pkg::RegionNone, 32'hFFFF_FFFF,
                                      32'h0, 32'h0, 16'h0));
    pending_words.push_back(make_word(ssrt_pkg::KindFree, ssrt_pkg::RegionNone, 32'h200,
                                      32'h0, 32'h0, 16'h0));

    // random: three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      for (int i = 0; i < 306; i++) begin
        rg = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 49) == 0) rg = ssrt_pkg::RegionNone;
        case ($urandom_range(0, 9))
          0: s = $urandom();
          1: s = ($urandom_range(0, 1)) ? 32'h0 : 32'hFFFF_FFFF;
          default: s = pool_addr();
        endcase
        if ($urandom_range(0, 99) < 55)
          pending_words.push_back(make_word(ssrt_pkg::KindAlloc, rg, s,
            ($urandom_range(0, 1)) ? 32'h0 : $urandom(),
            ($urandom_range(0, 2) == 0) ? $urandom() : 32'h0,
            16'($urandom())));
        else
          pending_words.push_back(make_word(ssrt_pkg::KindFree, 2'($urandom()), s, $urandom(),
                                            $urandom(), 16'($urandom())));
      end
      wait_drained();
      if (ph == 0) begin
        send_idle_pct = 85;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_rsps.size() == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/ssrt_pkg.sv
hdl/ssrt_req_if.sv
hdl/ssrt_rsp_if.sv
hdl/sorted_segment_region_table_core.sv
dv/sorted_segment_region_table_core_tb.sv
